>>> rtl/wsel_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsel_pkg
// shared widths, codes, state encoding and control structs of the
// weighted index selector
// ---------------------------------------------------------------------------
package wsel_pkg;

    localparam int CMD_W           = 2;
    localparam int WEIGHT_W        = 14;
    localparam int FRAC_W          = 30;
    localparam int ITEM_W          = 7;
    localparam int STATUS_W        = 2;
    localparam int TOTAL_W         = 21;
    localparam int MAX_ENTRIES_DEF = 128;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_DRAW   = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TARGET,
        ST_PROBE,
        ST_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the input item
        logic exec;      // run the command, start the scaling multiply on a draw
        logic target;    // form the target, open the search, first table read
        logic probe;     // one search step
        logic load_out;  // move the result into the output register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic draw_go;      // draw on a non-empty table
        logic single;       // table holds one entry
        logic search_last;  // this step closes the search
        logic out_free;     // output register can take a result
    } ctrl_sts_t;

endpackage

>>> rtl/wsel_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsel_ram
// simple dual port ram, one write port, one read port with registered data
// ---------------------------------------------------------------------------
module wsel_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/wsel_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsel_datapath
// cumulative table, totals, scaling multiplier, lower-bound search
// registers and output register
// ---------------------------------------------------------------------------
module wsel_datapath import wsel_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    output ctrl_sts_t           sts,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [WEIGHT_W-1:0] s_weight,
    input  logic [FRAC_W-1:0]   s_random_fraction,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ITEM_W-1:0]   m_item_index,
    output logic [STATUS_W-1:0] m_status,
    output logic [TOTAL_W-1:0]  m_total_weight
);

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int PROD_W = FRAC_W + TOTAL_W;

    cmd_t                cmd_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [PROD_W-1:0]   product_reg;
    logic [TOTAL_W-1:0]  target_reg;
    logic [IDX_W-1:0]    lo_reg;
    logic [IDX_W-1:0]    hi_reg;
    status_t             res_status_reg;
    logic                m_valid_reg;
    logic [ITEM_W-1:0]   out_item_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [TOTAL_W-1:0]  out_total_reg;

    logic                full;
    logic                empty;
    logic [TOTAL_W:0]    sum_ext;
    logic [TOTAL_W-1:0]  sum_sat;
    logic [PROD_W-1:0]   product;
    logic [IDX_W-1:0]    hi_init;
    logic [IDX_W-1:0]    mid_init;
    logic [IDX_W-1:0]    mid;
    logic [IDX_W-1:0]    lo_next;
    logic [IDX_W-1:0]    hi_next;
    logic [IDX_W-1:0]    mid_next;
    logic                hit;
    logic                ram_we;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [TOTAL_W-1:0]  ram_rdata;
    logic [IDX_W+ITEM_W-1:0] item_ext;

    assign full    = (count_reg == CNT_W'(MAX_ENTRIES));
    assign empty   = (count_reg == '0);
    assign sum_ext = {1'b0, total_reg} + (TOTAL_W + 1)'(weight_reg);
    assign sum_sat = sum_ext[TOTAL_W] ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
    assign product = PROD_W'(frac_reg) * PROD_W'(total_reg);

    // search bounds
    assign hi_init  = IDX_W'(count_reg - CNT_W'(1));
    assign mid_init = hi_init >> 1;
    assign mid      = IDX_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign hit      = (target_reg <= ram_rdata);
    assign lo_next  = hit ? lo_reg : mid + IDX_W'(1);
    assign hi_next  = hit ? mid : hi_reg;
    assign mid_next = IDX_W'(({1'b0, lo_next} + {1'b0, hi_next}) >> 1);

    assign ram_we    = cmd.exec && (cmd_reg == CMD_APPEND) && !full;
    assign ram_re    = cmd.target || cmd.probe;
    assign ram_raddr = cmd.probe ? mid_next : mid_init;

    wsel_ram #(
        .WIDTH (TOTAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (sum_sat),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sts.draw_go     = (cmd_reg == CMD_DRAW) && !empty;
    assign sts.single      = (count_reg == CNT_W'(1));
    assign sts.search_last = (lo_next == hi_next);
    assign sts.out_free    = !m_valid_reg || m_ready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                unique case (cmd_reg)
                    CMD_CLEAR: begin
                        count_reg <= '0;
                        total_reg <= '0;
                    end
                    CMD_APPEND: begin
                        if (!full) begin
                            count_reg <= count_reg + CNT_W'(1);
                            total_reg <= sum_sat;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg    <= cmd_t'(s_cmd);
            weight_reg <= s_weight;
            frac_reg   <= s_random_fraction;
        end
        if (cmd.exec) begin
            lo_reg      <= '0;
            product_reg <= product;
            unique case (cmd_reg)
                CMD_APPEND: res_status_reg <= full ? STS_FULL : STS_OK;
                CMD_DRAW:   res_status_reg <= empty ? STS_EMPTY : STS_OK;
                default:    res_status_reg <= STS_OK;
            endcase
        end
        if (cmd.target) begin
            target_reg <= product_reg[FRAC_W +: TOTAL_W] + TOTAL_W'(1);
            lo_reg     <= '0;
            hi_reg     <= hi_init;
        end
        if (cmd.probe) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (cmd.load_out) begin
            out_item_reg   <= item_ext[ITEM_W-1:0];
            out_status_reg <= res_status_reg;
            out_total_reg  <= total_reg;
        end
    end

    assign item_ext = {{ITEM_W{1'b0}}, lo_reg};

    assign m_valid        = m_valid_reg;
    assign m_item_index   = out_item_reg;
    assign m_status       = out_status_reg;
    assign m_total_weight = out_total_reg;

endmodule

>>> rtl/wsel_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsel_ctrl
// command sequencer: accept, execute, scale, search, respond
// ---------------------------------------------------------------------------
module wsel_ctrl import wsel_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.draw_go ? ST_TARGET : ST_RESP;
            end
            ST_TARGET: begin
                cmd.target = 1'b1;
                state_next = sts.single ? ST_RESP : ST_PROBE;
            end
            ST_PROBE: begin
                cmd.probe = 1'b1;
                if (sts.search_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/weighted_index_selector_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// weighted_index_selector_unit
// weighted random index selection over a table of cumulative weights
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    cmd, weight, random_fraction
//  m_        out        m_valid/m_ready    item_index, status, total_weight
//
//  clear, append and draw on an empty table run accept, execute and respond;
//  a draw on n entries adds the target step and, beyond a single entry, a
//  binary search; the result goes valid as s_ready rises for the next item;
//  the search makes one table probe per cycle on the single read
//  port of the table ram
//  one item is in work at a time; s_ready is high only between items
//  a result waiting in the output register does not block the next accept,
//  only the next result
//  reset (aresetn, synchronous, active low) empties the table and clears
//  the total; the table ram itself is never cleared
//
// ---------------------------------------------------------------------------
module weighted_index_selector_unit import wsel_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input items
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [WEIGHT_W-1:0] s_weight,
    input  logic [FRAC_W-1:0]   s_random_fraction,
    // result items
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ITEM_W-1:0]   m_item_index,
    output logic [STATUS_W-1:0] m_status,
    output logic [TOTAL_W-1:0]  m_total_weight
);

    // command and status between sequencer and datapath
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // sequencer: owns s_ready and the phase of each item
    wsel_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: table ram, running total, 30x21 scaling multiplier,
    // search bounds and the output register
    wsel_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_cmd             (s_cmd),
        .s_weight          (s_weight),
        .s_random_fraction (s_random_fraction),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_item_index      (m_item_index),
        .m_status          (m_status),
        .m_total_weight    (m_total_weight)
    );

endmodule

>>> rtl/wsel_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsel_checker
// port-level checks of the weighted index selector, bound to the top level
// ---------------------------------------------------------------------------
module wsel_checker import wsel_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [ITEM_W-1:0]   m_item_index,
    input logic [STATUS_W-1:0] m_status,
    input logic [TOTAL_W-1:0]  m_total_weight
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item_index)
            && $stable(m_status) && $stable(m_total_weight))
        else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in work");

    // failed commands report index zero
    a_fail_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STS_OK) |-> m_item_index == '0)
        else $error("non-zero index on a failed command");

    // an empty table has no weight
    a_empty_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STS_EMPTY) |-> m_total_weight == '0)
        else $error("empty table with non-zero total");

    // reset drops the output
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind weighted_index_selector_unit wsel_checker u_wsel_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for weighted_index_selector_unit: a queue of commands
// (clear, append, draw) feeds a valid/ready driver, a shadow copy of the
// cumulative weight table predicts every result item, and a monitor compares
// each result field by field in order under random stalls on both sides
// ---------------------------------------------------------------------------
module testbench;
    import wsel_pkg::*;

    // no package code for the unused command value; the block changes nothing on it
    localparam logic [CMD_W-1:0]    CMD_UNUSED        = 2'd3;
    localparam logic [WEIGHT_W-1:0] WEIGHT_TOP        = {WEIGHT_W{1'b1}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL_SCALE = 14'd10000;
    localparam logic [FRAC_W-1:0]   FRAC_TOP          = {FRAC_W{1'b1}};

    localparam int TARGET_ITEMS  = 1950;  // commands that do something
    localparam int HOLD_AT_ITEM  = 400;   // receiver hold-off starts here
    localparam int HOLD_CYCLES   = 300;
    localparam int CALM_FIRST    = 900;   // no idling on either side in
    localparam int CALM_LAST     = 1200;  // this window of accepted items
    localparam int DRAIN_CYCLES  = 16;    // longer than the slowest draw

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [WEIGHT_W-1:0] weight;
        logic [FRAC_W-1:0]   fraction;
    } request_t;

    typedef struct packed {
        logic [ITEM_W-1:0]  item_index;
        status_t            status;
        logic [TOTAL_W-1:0] total;
    } selection_t;

    logic                aclk              = 1'b0;
    logic                aresetn           = 1'b0;
    logic                s_valid           = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd             = CMD_CLEAR;
    logic [WEIGHT_W-1:0] s_weight          = '0;
    logic [FRAC_W-1:0]   s_random_fraction = '0;
    logic                m_valid;
    logic                m_ready           = 1'b0;
    logic [ITEM_W-1:0]   m_item_index;
    logic [STATUS_W-1:0] m_status;
    logic [TOTAL_W-1:0]  m_total_weight;

    // commands waiting to be offered, selections waiting to come out
    request_t   request_backlog[$];
    selection_t awaited_selections[$];

    // shadow state of the weight table
    logic [TOTAL_W-1:0] shadow_sums [MAX_ENTRIES_DEF];
    int unsigned        shadow_count = 0;
    logic [TOTAL_W-1:0] shadow_total = '0;

    int unsigned accepted_items = 0;
    int unsigned queued_useful  = 0;
    int unsigned mismatch_count = 0;
    logic        hold_off       = 1'b0;

    weighted_index_selector_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_weight          (s_weight),
        .s_random_fraction (s_random_fraction),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_item_index      (m_item_index),
        .m_status          (m_status),
        .m_total_weight    (m_total_weight)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // run ends here if the block hangs
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // apply one command to the shadow table, return the selection it yields
    function automatic selection_t predict_selection(request_t req);
        selection_t         sel;
        logic [TOTAL_W:0]   sum;
        logic [63:0]        scaled;
        int unsigned        target;
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        mid;
        sel.item_index = '0;
        sel.status     = STS_OK;
        case (req.cmd)
            CMD_CLEAR: begin
                shadow_count = 0;
                shadow_total = '0;
            end
            CMD_APPEND: begin
                if (shadow_count >= MAX_ENTRIES_DEF) begin
                    sel.status = STS_FULL;
                end else begin
                    // running sum saturates at the top of the total range
                    sum = {1'b0, shadow_total} + (TOTAL_W + 1)'(req.weight);
                    if (sum > {1'b0, TOTAL_MAX}) begin
                        sum = {1'b0, TOTAL_MAX};
                    end
                    shadow_sums[shadow_count] = sum[TOTAL_W-1:0];
                    shadow_total              = sum[TOTAL_W-1:0];
                    shadow_count++;
                end
            end
            CMD_DRAW: begin
                if (shadow_count == 0) begin
                    sel.status = STS_EMPTY;
                end else begin
                    // target = floor(fraction * total / 2^30) + 1
                    scaled = (64'(req.fraction) * 64'(shadow_total)) >> FRAC_W;
                    target = scaled[31:0] + 1;
                    // first entry whose running sum reaches the target
                    lo = 0;
                    hi = shadow_count - 1;
                    while (lo < hi) begin
                        mid = (lo + hi) >> 1;
                        if (target <= shadow_sums[mid]) begin
                            hi = mid;
                        end else begin
                            lo = mid + 1;
                        end
                    end
                    sel.item_index = ITEM_W'(lo);
                end
            end
            default: ;  // unused code, nothing changes
        endcase
        sel.total = shadow_total;
        return sel;
    endfunction

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // random idling on both sides, switched off in the calm window
    function automatic bit take_a_break();
        if (accepted_items >= CALM_FIRST && accepted_items < CALM_LAST) begin
            return 1'b0;
        end
        return $urandom_range(99) < 23;
    endfunction

    function automatic logic [WEIGHT_W-1:0] random_weight();
        case ($urandom_range(9))
            0:       return '0;
            1:       return WEIGHT_TOP;
            2, 3:    return WEIGHT_W'($urandom_range(15));
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    function automatic logic [FRAC_W-1:0] random_fraction();
        case ($urandom_range(9))
            0:       return '0;
            1:       return FRAC_TOP;
            default: return FRAC_W'($urandom);
        endcase
    endfunction

    task automatic queue_request(input logic [CMD_W-1:0] cmd,
                                 input logic [WEIGHT_W-1:0] weight,
                                 input logic [FRAC_W-1:0] fraction);
        request_backlog.push_back({cmd, weight, fraction});
        if (cmd != CMD_UNUSED) begin
            queued_useful++;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        mismatch_count++;
        $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued commands, predicts on each accepted item
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        request_t next_req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_selections.push_back(
                    predict_selection({s_cmd, s_weight, s_random_fraction}));
                accepted_items++;
            end
            // payload may only change once the current item is taken
            if (!s_valid || s_ready) begin
                if (request_backlog.size() != 0 && !take_a_break()) begin
                    next_req          = request_backlog.pop_front();
                    s_valid           <= 1'b1;
                    s_cmd             <= next_req.cmd;
                    s_weight          <= next_req.weight;
                    s_random_fraction <= next_req.fraction;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result item against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        selection_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_selections.size() == 0) begin
                    report_mismatch("result item with none awaited, status", m_status, 0);
                end else begin
                    want = awaited_selections.pop_front();
                    if (m_item_index !== want.item_index) begin
                        report_mismatch("item_index", m_item_index, want.item_index);
                    end
                    if (m_status !== want.status) begin
                        report_mismatch("status", m_status, want.status);
                    end
                    if (m_total_weight !== want.total) begin
                        report_mismatch("total_weight", m_total_weight, want.total);
                    end
                end
            end
            m_ready <= !hold_off && !take_a_break();
        end
    end

    // long receiver hold-off while the sender keeps offering, so the
    // output register fills and s_ready has to drop
    initial begin
        while (accepted_items < HOLD_AT_ITEM) begin
            @(posedge aclk);
        end
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int unsigned fill;
        int unsigned draws;
        int unsigned offered_total;

        // empty table draws at both fraction extremes
        queue_request(CMD_DRAW, '0, '0);
        queue_request(CMD_DRAW, WEIGHT_TOP, FRAC_TOP);
        // all weights zero: search ends on the last entry
        queue_request(CMD_APPEND, '0, '0);
        queue_request(CMD_DRAW, '0, FRAC_TOP);
        queue_request(CMD_APPEND, '0, FRAC_TOP);
        queue_request(CMD_DRAW, '0, '0);
        // weight above full scale, then full scale
        queue_request(CMD_APPEND, WEIGHT_TOP, '0);
        queue_request(CMD_APPEND, WEIGHT_FULL_SCALE, '0);
        queue_request(CMD_DRAW, '0, '0);
        queue_request(CMD_DRAW, '0, FRAC_TOP);
        // unused command with every payload bit set
        queue_request(CMD_UNUSED, WEIGHT_TOP, FRAC_TOP);
        queue_request(CMD_APPEND, 14'd1, '0);
        queue_request(CMD_DRAW, '0, FRAC_TOP);
        // clear, then draw on the emptied table
        queue_request(CMD_CLEAR, WEIGHT_TOP, FRAC_TOP);
        queue_request(CMD_DRAW, '0, FRAC_TOP);
        // single entry table
        queue_request(CMD_APPEND, 14'd1, '0);
        queue_request(CMD_DRAW, '0, '0);
        queue_request(CMD_CLEAR, '0, '0);

        // random fill-and-draw sequences; some skip the clear, some run
        // past the table size to hit the full case, some draw on empty
        while (queued_useful < TARGET_ITEMS) begin
            if ($urandom_range(9) != 0) begin
                queue_request(CMD_CLEAR, random_weight(), random_fraction());
            end
            if ($urandom_range(9) == 0) begin
                fill = $urandom_range(MAX_ENTRIES_DEF + 6, MAX_ENTRIES_DEF - 4);
            end else begin
                fill = $urandom_range(20);
            end
            repeat (fill) begin
                queue_request(CMD_APPEND, random_weight(), random_fraction());
                if ($urandom_range(19) == 0) begin
                    queue_request(CMD_UNUSED, WEIGHT_W'($urandom), FRAC_W'($urandom));
                end
            end
            draws = $urandom_range(12, 1);
            repeat (draws) begin
                queue_request(CMD_DRAW, random_weight(), random_fraction());
            end
        end
        offered_total = request_backlog.size();

        // all items taken, all results back, then a short drain
        while (accepted_items < offered_total || awaited_selections.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/wsel_pkg.sv
rtl/wsel_ram.sv
rtl/wsel_datapath.sv
rtl/wsel_ctrl.sv
rtl/weighted_index_selector_unit.sv
rtl/wsel_checker.sv
tb/sv/testbench.sv
